FILE: src/weighted_tensor_accumulate_macros.svh
// Assertion macros shared by the aggregation block.
`ifndef WEIGHTED_TENSOR_ACCUMULATE_MACROS_SVH
`define WEIGHTED_TENSOR_ACCUMULATE_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/wta_pkg.sv
`default_nettype none

package wta_pkg;

  localparam int IDX_W  = 12;
  localparam int VAL_W  = 64;
  localparam int TYPE_W = 3;

  // Queue between the front and the back, and the result queue.
  localparam int MQ_DEPTH = 8;
  localparam int MQ_CNT_W = 4;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CNT_W = 3;
  localparam int FE_CNT_W = 3;

  typedef enum logic [1:0] {
    WSEL_8  = 2'd0,
    WSEL_16 = 2'd1,
    WSEL_32 = 2'd2,
    WSEL_64 = 2'd3
  } width_sel_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             neg;
    width_sel_t       wsel;
    logic             sgn;
    logic             first;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [VAL_W-1:0] mag;
  } work_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] sum;
  } result_t;

  function automatic logic [VAL_W-1:0] type_mask(input width_sel_t ws);
    logic [VAL_W-1:0] m;
    case (ws)
      WSEL_8:  m = 64'h0000_0000_0000_00FF;
      WSEL_16: m = 64'h0000_0000_0000_FFFF;
      WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
      WSEL_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic type_msb(input width_sel_t ws, input logic [VAL_W-1:0] v);
    logic b;
    case (ws)
      WSEL_8:  b = v[7];
      WSEL_16: b = v[15];
      WSEL_32: b = v[31];
      WSEL_64: b = v[63];
      default: b = v[63];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: src/weighted_tensor_accumulate.sv
// Throughput: one word per cycle while full is low; the multiplier pipeline and the
// store's read port and write port each take one word a cycle, with forwarding for
// repeated indices.
// Reset (synchronous, rst_n low) empties both queues and the pipelines; the sum
// store is not cleared, so an entry is undefined until written with first_model set.
`default_nettype none

`include "weighted_tensor_accumulate_macros.svh"

module weighted_tensor_accumulate #(
  parameter int DEPTH            = 4096,
  parameter int WEIGHT_FRAC_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [wta_pkg::IDX_W-1:0]      in_elem_index,
  input  wire logic [wta_pkg::VAL_W-1:0]      in_elem_value,
  input  wire logic [wta_pkg::TYPE_W-1:0]     in_elem_type,
  input  wire logic [WEIGHT_FRAC_BITS:0]      in_weight,
  input  wire logic                           in_first_model,
  output logic                                empty,
  input  wire logic                           pop,
  output logic      [wta_pkg::IDX_W-1:0]      out_index,
  output logic      [wta_pkg::VAL_W-1:0]      out_sum_value
);

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORK_W = $bits(wta_pkg::work_t);
  localparam int RES_W  = $bits(wta_pkg::result_t);
  localparam int OCC_W  = wta_pkg::MQ_CNT_W + 1;

  logic                          accept;
  logic                          fe_valid;
  wta_pkg::work_t                fe_work;
  logic [SLOT_W-1:0]             fe_slot;
  logic [wta_pkg::FE_CNT_W-1:0]  fe_inflight;

  logic [SLOT_W+WORK_W-1:0]      mq_rdata;
  logic [wta_pkg::MQ_CNT_W-1:0]  mq_count;
  logic                          mq_pop;
  wta_pkg::work_t                mq_work;
  logic [SLOT_W-1:0]             mq_slot;

  logic                          res_valid;
  wta_pkg::result_t              res;
  wta_pkg::result_t              oq_head;
  logic [RES_W-1:0]              oq_rdata;
  logic [wta_pkg::OQ_CNT_W-1:0]  oq_count;
  logic [OCC_W-1:0]              occupancy;

  // Words in the front pipeline hold a reserved place in the middle queue.
  assign occupancy = {1'b0, mq_count} + OCC_W'(fe_inflight);
  assign full      = occupancy >= OCC_W'(wta_pkg::MQ_DEPTH);
  assign accept    = push && !full;

  wta_front #(
    .DEPTH            (DEPTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_idx    (in_elem_index),
    .in_value  (in_elem_value),
    .in_type   (in_elem_type),
    .in_weight (in_weight),
    .in_first  (in_first_model),
    .out_valid (fe_valid),
    .out_work  (fe_work),
    .out_slot  (fe_slot),
    .inflight  (fe_inflight)
  );

  wta_fifo #(
    .WIDTH (SLOT_W + WORK_W),
    .DEPTH (wta_pkg::MQ_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_valid),
    .wdata ({fe_slot, fe_work}),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .count (mq_count)
  );

  assign mq_work = wta_pkg::work_t'(mq_rdata[WORK_W-1:0]);
  assign mq_slot = mq_rdata[SLOT_W+WORK_W-1:WORK_W];

  wta_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mq_valid  (mq_count != '0),
    .mq_work   (mq_work),
    .mq_slot   (mq_slot),
    .mq_pop    (mq_pop),
    .oq_count  (oq_count),
    .res_valid (res_valid),
    .res       (res)
  );

  wta_fifo #(
    .WIDTH (RES_W),
    .DEPTH (wta_pkg::OQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .pop   (pop && !empty),
    .rdata (oq_rdata),
    .count (oq_count)
  );

  assign oq_head       = wta_pkg::result_t'(oq_rdata);
  assign empty         = (oq_count == '0);
  assign out_index     = oq_head.idx;
  assign out_sum_value = oq_head.sum;

  `ASSERT_IMPLIES(a_mid_credit, clk, rst_n, 1'b1, occupancy <= OCC_W'(wta_pkg::MQ_DEPTH), "middle queue reservations exceeded")
  `ASSERT_NEXT(a_accept_enters_front, clk, rst_n, accept, fe_inflight != '0, "accepted word missing from the front pipeline")

endmodule

`default_nettype wire

FILE: src/wta_ram.sv
`default_nettype none

module wta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Read-first: a read and a write to one address in a cycle return the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: src/wta_fifo.sv
`default_nettype none

`include "weighted_tensor_accumulate_macros.svh"

module wta_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic                         pop,
  output logic      [WIDTH-1:0]             rdata,
  output logic      [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;

  `ASSERT_IMPLIES(a_fifo_no_overflow, clk, rst_n, push && !pop, count_r != CNT_W'(DEPTH), "word pushed into a full queue")
  `ASSERT_IMPLIES(a_fifo_no_underflow, clk, rst_n, pop, count_r != '0, "word popped from an empty queue")

endmodule

`default_nettype wire

FILE: src/wta_front.sv
`default_nettype none

module wta_front #(
  parameter int DEPTH            = 4096,
  parameter int WEIGHT_FRAC_BITS = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_valid,
  input  wire logic [wta_pkg::IDX_W-1:0]                   in_idx,
  input  wire logic [wta_pkg::VAL_W-1:0]                   in_value,
  input  wire logic [wta_pkg::TYPE_W-1:0]                  in_type,
  input  wire logic [WEIGHT_FRAC_BITS:0]                   in_weight,
  input  wire logic                                        in_first,
  output logic                                             out_valid,
  output wta_pkg::work_t                                   out_work,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     out_slot,
  output logic [wta_pkg::FE_CNT_W-1:0]                     inflight
);

  localparam int WW      = WEIGHT_FRAC_BITS + 1;
  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ABITS   = (DEPTH > 1) ? $clog2(DEPTH) : 0;
  localparam int IW      = wta_pkg::IDX_W;
  localparam int VW      = wta_pkg::VAL_W;
  // Reciprocal for an exact floor(idx / DEPTH) over every index value.
  localparam int K       = IW + ABITS;
  localparam int RECIP_W = K + 1;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
  localparam int DW      = $clog2(DEPTH + 1);
  localparam logic [WW-1:0] ONE = WW'(1) << WEIGHT_FRAC_BITS;

  // Stage 1: classify, magnitude, weight clamp, quotient of the index.
  logic                s1_valid_r;
  wta_pkg::tag_t       s1_tag_r, s1_tag_nxt;
  logic [VW-1:0]       s1_mag_r, s1_mag_nxt;
  logic [WW-1:0]       s1_weight_r, s1_weight_nxt;
  logic [IW-1:0]       s1_q_r, s1_q_nxt;

  logic [VW-1:0]       val_m;
  logic [VW-1:0]       mask;
  logic [IW+RECIP_W-1:0] qprod;

  always_comb begin
    s1_tag_nxt.idx   = in_idx;
    s1_tag_nxt.wsel  = wta_pkg::width_sel_t'(in_type[1:0]);
    s1_tag_nxt.sgn   = in_type[2];
    s1_tag_nxt.first = in_first;
    mask             = wta_pkg::type_mask(s1_tag_nxt.wsel);
    val_m            = in_value & mask;
    s1_tag_nxt.neg   = s1_tag_nxt.sgn && wta_pkg::type_msb(s1_tag_nxt.wsel, val_m);
    s1_mag_nxt       = s1_tag_nxt.neg ? ((~val_m + 1'b1) & mask) : val_m;
    s1_weight_nxt    = (in_weight > ONE) ? ONE : in_weight;
    qprod            = {{RECIP_W{1'b0}}, in_idx} * {{IW{1'b0}}, RECIP};
    s1_q_nxt         = qprod[K +: IW];
  end

  // Stage 2: four 32x32 partial products and the storage slot.
  logic                s2_valid_r;
  wta_pkg::tag_t       s2_tag_r;
  logic [63:0]         s2_p00_r, s2_p01_r, s2_p10_r, s2_p11_r;
  logic [63:0]         s2_p00_nxt, s2_p01_nxt, s2_p10_nxt, s2_p11_nxt;
  logic [SLOT_W-1:0]   s2_slot_r, s2_slot_nxt;

  logic [63:0]         wext;
  logic [IW+DW-1:0]    qd;
  logic [IW+DW-1:0]    rem;

  always_comb begin
    wext       = 64'(s1_weight_r);
    s2_p00_nxt = {32'd0, s1_mag_r[31:0]}  * {32'd0, wext[31:0]};
    s2_p01_nxt = {32'd0, s1_mag_r[31:0]}  * {32'd0, wext[63:32]};
    s2_p10_nxt = {32'd0, s1_mag_r[63:32]} * {32'd0, wext[31:0]};
    s2_p11_nxt = {32'd0, s1_mag_r[63:32]} * {32'd0, wext[63:32]};
    qd         = {{DW{1'b0}}, s1_q_r} * (IW + DW)'(DEPTH);
    rem        = {{DW{1'b0}}, s1_tag_r.idx} - qd;
    s2_slot_nxt = rem[SLOT_W-1:0];
  end

  // Stage 3: fold the two middle products.
  logic                s3_valid_r;
  wta_pkg::tag_t       s3_tag_r;
  logic [SLOT_W-1:0]   s3_slot_r;
  logic [63:0]         s3_lo_r, s3_hi_r;
  logic [64:0]         s3_mid_r, s3_mid_nxt;

  assign s3_mid_nxt = {1'b0, s2_p01_r} + {1'b0, s2_p10_r};

  // Stage 4: full product, fraction dropped.
  logic                s4_valid_r;
  wta_pkg::tag_t       s4_tag_r;
  logic [SLOT_W-1:0]   s4_slot_r;
  logic [VW-1:0]       s4_mag_r, s4_mag_nxt;
  logic [127:0]        prod;

  always_comb begin
    prod       = {s3_hi_r, s3_lo_r} + ({63'd0, s3_mid_r} << 32);
    s4_mag_nxt = prod[WEIGHT_FRAC_BITS +: VW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag_r    <= s1_tag_nxt;
    s1_mag_r    <= s1_mag_nxt;
    s1_weight_r <= s1_weight_nxt;
    s1_q_r      <= s1_q_nxt;
    s2_tag_r    <= s1_tag_r;
    s2_p00_r    <= s2_p00_nxt;
    s2_p01_r    <= s2_p01_nxt;
    s2_p10_r    <= s2_p10_nxt;
    s2_p11_r    <= s2_p11_nxt;
    s2_slot_r   <= s2_slot_nxt;
    s3_tag_r    <= s2_tag_r;
    s3_slot_r   <= s2_slot_r;
    s3_lo_r     <= s2_p00_r;
    s3_hi_r     <= s2_p11_r;
    s3_mid_r    <= s3_mid_nxt;
    s4_tag_r    <= s3_tag_r;
    s4_slot_r   <= s3_slot_r;
    s4_mag_r    <= s4_mag_nxt;
  end

  assign out_valid    = s4_valid_r;
  assign out_work.tag = s4_tag_r;
  assign out_work.mag = s4_mag_r;
  assign out_slot     = s4_slot_r;
  assign inflight     = wta_pkg::FE_CNT_W'(s1_valid_r) + wta_pkg::FE_CNT_W'(s2_valid_r)
                      + wta_pkg::FE_CNT_W'(s3_valid_r) + wta_pkg::FE_CNT_W'(s4_valid_r);

endmodule

`default_nettype wire

FILE: src/wta_back.sv
`default_nettype none

`include "weighted_tensor_accumulate_macros.svh"

module wta_back #(
  parameter int DEPTH = 4096
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        mq_valid,
  input  wire wta_pkg::work_t                              mq_work,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mq_slot,
  output logic                                             mq_pop,
  input  wire logic [wta_pkg::OQ_CNT_W-1:0]                oq_count,
  output logic                                             res_valid,
  output wta_pkg::result_t                                 res
);

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VW     = wta_pkg::VAL_W;
  localparam int RW     = wta_pkg::OQ_CNT_W + 1;

  logic                b1_valid_r;
  wta_pkg::work_t      b1_work_r;
  logic [SLOT_W-1:0]   b1_slot_r;
  logic                last_valid_r;
  logic [SLOT_W-1:0]   last_slot_r;
  logic [VW-1:0]       last_data_r;
  logic [VW-1:0]       ram_rdata;

  logic [VW-1:0]       base;
  logic [VW-1:0]       addend;
  logic [VW-1:0]       raw;
  logic [VW-1:0]       mask;
  logic [VW-1:0]       sum;
  logic                fwd_hit;

  // Results in flight are counted against the result queue before a word leaves.
  assign mq_pop = mq_valid &&
                  (({1'b0, oq_count} + RW'(b1_valid_r)) < RW'(wta_pkg::OQ_DEPTH));

  wta_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (b1_valid_r),
    .waddr (b1_slot_r),
    .wdata (sum),
    .raddr (mq_slot),
    .rdata (ram_rdata)
  );

  // The RAM read overlaps the write of the word just before; that one is forwarded.
  always_comb begin
    fwd_hit = last_valid_r && (last_slot_r == b1_slot_r);
    if (b1_work_r.tag.first) begin
      base = '0;
    end else if (fwd_hit) begin
      base = last_data_r;
    end else begin
      base = ram_rdata;
    end
    addend = b1_work_r.mag ^ {VW{b1_work_r.tag.neg}};
    raw    = base + addend + VW'(b1_work_r.tag.neg);
    mask   = wta_pkg::type_mask(b1_work_r.tag.wsel);
    sum    = raw & mask;
    if (b1_work_r.tag.sgn && wta_pkg::type_msb(b1_work_r.tag.wsel, sum)) begin
      sum = sum | ~mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r   <= 1'b0;
      last_valid_r <= 1'b0;
    end else begin
      b1_valid_r   <= mq_pop;
      last_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      b1_work_r <= mq_work;
      b1_slot_r <= mq_slot;
    end
    last_slot_r <= b1_slot_r;
    last_data_r <= sum;
  end

  assign res_valid = b1_valid_r;
  assign res.idx   = b1_work_r.tag.idx;
  assign res.sum   = sum;

  `ASSERT_IMPLIES(a_unsigned_zero_ext, clk, rst_n, b1_valid_r && !b1_work_r.tag.sgn && (b1_work_r.tag.wsel == wta_pkg::WSEL_8), sum[VW-1:8] == '0, "unsigned byte sum not zero extended")

endmodule

`default_nettype wire

FILE: tb/weighted_tensor_accumulate_tb.sv
`default_nettype none

module weighted_tensor_accumulate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W  = wta_pkg::IDX_W;
  localparam int VAL_W  = wta_pkg::VAL_W;
  localparam int TYPE_W = wta_pkg::TYPE_W;

  localparam int FRAC = 32;
  localparam int SLOTS = 4096;
  localparam logic [FRAC:0] W_ONE = 33'h1_0000_0000;

  localparam logic [2:0] TY_U8  = {1'b0, wta_pkg::WSEL_8};
  localparam logic [2:0] TY_U16 = {1'b0, wta_pkg::WSEL_16};
  localparam logic [2:0] TY_U32 = {1'b0, wta_pkg::WSEL_32};
  localparam logic [2:0] TY_U64 = {1'b0, wta_pkg::WSEL_64};
  localparam logic [2:0] TY_S8  = {1'b1, wta_pkg::WSEL_8};
  localparam logic [2:0] TY_S16 = {1'b1, wta_pkg::WSEL_16};
  localparam logic [2:0] TY_S32 = {1'b1, wta_pkg::WSEL_32};
  localparam logic [2:0] TY_S64 = {1'b1, wta_pkg::WSEL_64};

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    logic [TYPE_W-1:0] typ;
    logic [FRAC:0]     wt;
    logic              first;
    int unsigned       gap;
    bit                drain;
  } elem_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [IDX_W-1:0]  in_elem_index = '0;
  logic [VAL_W-1:0]  in_elem_value = '0;
  logic [TYPE_W-1:0] in_elem_type = '0;
  logic [FRAC:0]     in_weight = '0;
  logic              in_first_model = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [IDX_W-1:0] out_index;
  logic [VAL_W-1:0] out_sum_value;

  elem_word_t   pending_elems[$];
  wta_pkg::result_t expected_sums[$];
  logic [VAL_W-1:0] running_sums[SLOTS];
  bit           written_idx[SLOTS];
  int unsigned  used_idx[$];
  int unsigned  errors = 0;
  int unsigned  results_seen = 0;
  bit           in_took = 1'b0;
  bit           out_took = 1'b0;
  int unsigned  tx_wait = 0;
  bit           tx_wait_set = 1'b0;
  int unsigned  rx_wait = 0;

  weighted_tensor_accumulate dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_elem_index  (in_elem_index),
    .in_elem_value  (in_elem_value),
    .in_elem_type   (in_elem_type),
    .in_weight      (in_weight),
    .in_first_model (in_first_model),
    .empty          (empty),
    .pop            (pop),
    .out_index      (out_index),
    .out_sum_value  (out_sum_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Weighted accumulate of one element into the local copy of the sum store.
  function automatic logic [VAL_W-1:0] accumulate_elem(input logic [IDX_W-1:0] idx,
                                                        input logic [VAL_W-1:0] val,
                                                        input logic [TYPE_W-1:0] typ,
                                                        input logic [FRAC:0] wt,
                                                        input logic first);
    wta_pkg::width_sel_t ws;
    int unsigned w;
    logic [VAL_W-1:0] m, v, mag, scaled, acc;
    logic [127:0] prod;
    logic neg;
    ws = wta_pkg::width_sel_t'(typ[1:0]);
    case (ws)
      wta_pkg::WSEL_8:  w = 8;
      wta_pkg::WSEL_16: w = 16;
      wta_pkg::WSEL_32: w = 32;
      default: w = 64;
    endcase
    m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    if (wt > W_ONE) wt = W_ONE;
    v = val & m;
    neg = typ[2] && v[w-1];
    mag = neg ? ((~v + 64'd1) & m) : v;
    prod = {64'd0, mag} * {95'd0, wt};
    // Dropping the fraction of the magnitude truncates toward zero.
    scaled = prod[FRAC+63:FRAC];
    if (neg) scaled = ~scaled + 64'd1;
    acc = ((first ? 64'd0 : running_sums[idx]) + scaled) & m;
    if (typ[2] && acc[w-1]) acc = acc | ~m;
    running_sums[idx] = acc;
    return acc;
  endfunction

  // An entry never written must not be read, so its first word starts the sum.
  function automatic void add_elem(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val,
                                   input logic [TYPE_W-1:0] typ, input logic [FRAC:0] wt,
                                   input logic first, input int unsigned gap, input bit drain);
    elem_word_t e;
    e.idx = idx;
    e.val = val;
    e.typ = typ;
    e.wt = wt;
    e.first = first || !written_idx[idx];
    e.gap = gap;
    e.drain = drain;
    if (!written_idx[idx]) used_idx.push_back(idx);
    written_idx[idx] = 1'b1;
    pending_elems.push_back(e);
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = ~(64'd1 << $urandom_range(0, 63));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [FRAC:0] draw_weight();
    logic [FRAC:0] wt;
    case ($urandom_range(0, 9))
      0: wt = '0;
      1: wt = W_ONE;
      2: wt = {1'b1, 32'($urandom)};
      default: wt = {1'b0, 32'($urandom)};
    endcase
    return wt;
  endfunction

  function automatic int unsigned draw_gap(input int unsigned n);
    if ((n / 40) % 4 == 2) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
  endfunction

  always @(posedge clk) begin : monitor
    wta_pkg::result_t want;
    in_took <= rst_n && push && !full;
    out_took <= rst_n && pop && !empty;
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected word, expected none, got index 0x%h sum 0x%h",
                 $time, out_index, out_sum_value);
        errors++;
      end else begin
        want = expected_sums.pop_front();
        if (out_index !== want.idx) begin
          $display("%0t: index mismatch, expected 0x%h, got 0x%h", $time, want.idx, out_index);
          errors++;
        end
        if (out_sum_value !== want.sum) begin
          $display("%0t: sum mismatch at index 0x%h, expected 0x%h, got 0x%h",
                   $time, want.idx, want.sum, out_sum_value);
          errors++;
        end
      end
    end
    if (rst_n && push && !full) begin
      want.idx = in_elem_index;
      want.sum = accumulate_elem(in_elem_index, in_elem_value, in_elem_type, in_weight,
                                 in_first_model);
      expected_sums.push_back(want);
    end
  end

  always @(negedge clk) begin : driver
    elem_word_t e;
    logic nxt;
    nxt = push && !in_took;
    if (rst_n && !nxt && pending_elems.size() != 0) begin
      if (!tx_wait_set) begin
        tx_wait = pending_elems[0].gap;
        tx_wait_set = 1'b1;
      end
      if (tx_wait > 0) begin
        tx_wait--;
      end else if (!(pending_elems[0].drain && expected_sums.size() != 0)) begin
        e = pending_elems.pop_front();
        in_elem_index <= e.idx;
        in_elem_value <= e.val;
        in_elem_type <= e.typ;
        in_weight <= e.wt;
        in_first_model <= e.first;
        tx_wait_set = 1'b0;
        nxt = 1'b1;
      end
    end
    push <= nxt;
  end

  // The receiver stalls a random number of cycles after each word, with calm stretches.
  always @(negedge clk) begin : receiver
    logic nxt;
    if (out_took) rx_wait = ((results_seen / 48) % 3 == 1) ? 0 : $urandom_range(0, 18);
    if (pop && !out_took) begin
      nxt = 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      nxt = 1'b0;
    end else begin
      nxt = 1'b1;
    end
    pop <= nxt;
  end

  initial begin : stimulus
    int unsigned total, n_el, n_mod, base, idx;
    logic [TYPE_W-1:0] rtype;
    logic [FRAC:0] wt;
    bit mixed;

    // Wrap in narrow types and the most negative values.
    add_elem(12'd0, 64'hFF, TY_U8, W_ONE, 1'b1, 0, 1'b0);
    add_elem(12'd0, 64'h01, TY_U8, W_ONE, 1'b0, 0, 1'b0);
    add_elem(12'd4095, 64'h80, TY_S8, W_ONE, 1'b1, 0, 1'b0);
    add_elem(12'd4095, 64'h80, TY_S8, 33'h0_8000_0000, 1'b0, 0, 1'b0);
    // A weight above one is clamped to exactly one.
    add_elem(12'd1, '1, TY_U64, 33'h1_FFFF_FFFF, 1'b1, 0, 1'b0);
    add_elem(12'd1, '1, TY_U64, 33'h0_FFFF_FFFF, 1'b0, 0, 1'b0);
    add_elem(12'd2, 64'h8000_0000_0000_0000, TY_S64, W_ONE, 1'b1, 0, 1'b0);
    add_elem(12'd2, 64'h7FFF_FFFF_FFFF_FFFF, TY_S64, '0, 1'b0, 0, 1'b0);
    // Upper bits beyond the type width are ignored; the type changes at one index.
    add_elem(12'd3, 64'hFFFF_FFFF_FFFF_1234, TY_U16, 33'h0_C000_0000, 1'b1, 0, 1'b0);
    add_elem(12'd3, 64'hFFFF, TY_S16, W_ONE, 1'b0, 0, 1'b0);
    add_elem(12'd3, 64'hA5A5_A5A5_8000_0001, TY_U32, W_ONE, 1'b0, 0, 1'b0);
    add_elem(12'd3, 64'h0000_0000_8000_0000, TY_S32, 33'h1_0000_0001, 1'b0, 0, 1'b0);
    // Negative products truncate toward zero, not down.
    add_elem(12'd5, 64'h81, TY_S8, 33'h0_0100_0000, 1'b1, 0, 1'b0);
    add_elem(12'd5, 64'hFF, TY_S8, 33'h0_8000_0000, 1'b0, 0, 1'b0);
    // Back-to-back words to one index exercise forwarding.
    add_elem(12'd6, 64'hFFFF_FFFF, TY_U32, W_ONE, 1'b1, 0, 1'b0);
    add_elem(12'd6, 64'hFFFF_FFFF, TY_U32, W_ONE, 1'b0, 0, 1'b0);
    add_elem(12'd6, 64'h1234_5678, TY_U32, 33'h0_4000_0000, 1'b0, 0, 1'b0);
    add_elem(12'd6, 64'h8765_4321, TY_S32, 33'h0_7FFF_FFFF, 1'b0, 0, 1'b0);
    add_elem(12'd2048, 64'h5555_5555_5555_5555, TY_S16, 33'h0_AAAA_AAAA, 1'b1, 3, 1'b0);
    add_elem(12'd7, {$urandom, $urandom}, TY_U8, draw_weight(), 1'b1, 0, 1'b0);
    add_elem(12'd7, {$urandom, $urandom}, TY_U64, draw_weight(), 1'b0, 0, 1'b0);
    add_elem(12'd7, {$urandom, $urandom}, TY_S64, draw_weight(), 1'b0, 0, 1'b0);

    total = 0;
    while (total < 650) begin
      if ($urandom_range(0, 9) < 7) begin
        // One aggregation round: several models update the same block of elements.
        n_el = $urandom_range(1, 8);
        n_mod = $urandom_range(2, 5);
        base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SLOTS - 8) : $urandom_range(0, 24);
        rtype = TYPE_W'($urandom_range(0, 7));
        mixed = ($urandom_range(0, 4) == 0);
        for (int mdl = 0; mdl < n_mod; mdl++) begin
          wt = draw_weight();
          for (int e = 0; e < n_el; e++) begin
            add_elem(IDX_W'(base + e), draw_value(),
                     mixed ? TYPE_W'($urandom_range(0, 7)) : rtype, wt, mdl == 0,
                     draw_gap(total), total % 160 == 5);
            total++;
          end
        end
      end else begin
        if ($urandom_range(0, 1) && used_idx.size() != 0)
          idx = used_idx[$urandom_range(0, used_idx.size() - 1)];
        else
          idx = $urandom_range(0, SLOTS - 1);
        add_elem(IDX_W'(idx), {$urandom, $urandom}, TYPE_W'($urandom_range(0, 7)),
                 {1'($urandom_range(0, 1)), 32'($urandom)}, 1'($urandom_range(0, 1)),
                 draw_gap(total), total % 160 == 5);
        total++;
      end
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    while (pending_elems.size() != 0 || push || expected_sums.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (expected_sums.size() != 0) begin
      $display("%0t: missing word, expected index 0x%h sum 0x%h, got none",
               $time, expected_sums[0].idx, expected_sums[0].sum);
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
